### rtl/ric_pkg.sv
// shared types and constants of the raster interrupt controller
package ric_pkg;

	localparam int LineW = 9;
	localparam int FlagW = 8;
	localparam int EnW   = 4;

	localparam logic [LineW-1:0] LastLineRst = 9'd311;
	localparam logic [LineW-1:0] FirstDraw   = 9'd51;
	localparam logic [LineW-1:0] LastDraw    = 9'd250;
	localparam logic [FlagW-1:0] AnyFlagBit  = 8'h80;
	localparam logic [EnW-1:0]   RasterSrc   = 4'h1;
	localparam logic [FlagW-1:0] ClearMask   = 8'h8f;

	typedef enum logic [2:0] {
		FN_TICK     = 3'd0,
		FN_EVENT    = 3'd1,
		FN_WR_FLAGS = 3'd2,
		FN_WR_EN    = 3'd3,
		FN_RD_FLAGS = 3'd4,
		FN_RD_EN    = 3'd5,
		FN_WR_CMP   = 3'd6
	} func_t;

	typedef struct packed {
		logic [2:0]       func;
		logic [LineW-1:0] data;
		logic [EnW-1:0]   event_bits;
		logic             cpu_accepts;
	} item_t;

	typedef struct packed {
		logic [7:0]       read_data;
		logic             irq_line;
		logic [LineW-1:0] raster_line;
		logic             draw_valid;
		logic [7:0]       draw_row;
	} result_t;

endpackage

### rtl/raster_interrupt_controller.sv
// top level of the raster interrupt controller: stream ports and result register
//
// One word is taken per clock while s_tready is high: each accepted word (tick,
// event, register read or write) updates the controller state in the same cycle
// and its result word appears on the master side in the next cycle, held in a
// single output register. With m_tready high the block sustains one word per
// cycle; s_tready follows the output register (free, or being emptied this cycle).
// The last-line register is to be written through cfg_* only while the block
// is idle, not enforced by the block; cfg_ready is always high. After reset it is 311.
module raster_interrupt_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // data[8:0], event_bits[12:9], cpu_accepts[13], zero pad
	input  logic [2:0]  s_tuser,   // func[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // read_data[7:0], irq_line[8], raster_line[17:9],
	                               // draw_valid[18], draw_row[26:19], zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [ric_pkg::LineW-1:0] cfg_data
);
	import ric_pkg::*;

	logic [LineW-1:0] last_line_q;
	logic             out_valid_q;
	result_t          out_q;
	result_t          res;
	item_t            item;
	logic             s_take;

	assign cfg_ready = 1'b1;
	assign s_tready  = !out_valid_q || m_tready;
	assign s_take    = s_tvalid && s_tready;

	assign item.func        = s_tuser;
	assign item.data        = s_tdata[8:0];
	assign item.event_bits  = s_tdata[12:9];
	assign item.cpu_accepts = s_tdata[13];

	ric_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (s_take),
		.item      (item),
		.last_line (last_line_q),
		.result    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_line_q <= LastLineRst;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				last_line_q <= cfg_data;
			if (s_take)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_take)
			out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, out_q.draw_row, out_q.draw_valid, out_q.raster_line,
		out_q.irq_line, out_q.read_data};

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_tready)
		else $error("input stalled with empty output register");

	a_take_fills: assert property (@(posedge clk) disable iff (!arst_n)
		s_take |=> out_valid_q)
		else $error("accepted word produced no result");

	a_draw_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.draw_valid) |->
			(out_q.raster_line >= FirstDraw && out_q.raster_line <= LastDraw &&
			out_q.draw_row == 8'(out_q.raster_line - FirstDraw)))
		else $error("draw row outside visible window");

endmodule

### rtl/ric_core.sv
// controller state registers and the per-word update logic
module ric_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  ric_pkg::item_t            item,
	input  logic [ric_pkg::LineW-1:0] last_line,
	output ric_pkg::result_t          result
);
	import ric_pkg::*;

	logic [LineW-1:0] raster_q, raster_d;
	logic             frame_q, frame_d;
	logic [FlagW-1:0] flags_q, flags_d;
	logic [EnW-1:0]   en_q, en_d;
	logic             req_q, req_d;
	logic [LineW-1:0] cmp_q, cmp_d;

	logic [LineW:0]   inc;
	logic             wrap;
	logic [LineW-1:0] tick_line;
	logic             tick_frame;
	logic [EnW-1:0]   raise_mask;
	logic             raise;
	logic [FlagW-1:0] cleared;
	logic [LineW-1:0] row_full;

	assign inc        = {1'b0, raster_q} + {{LineW{1'b0}}, 1'b1};
	assign wrap       = inc > {1'b0, last_line};
	assign tick_line  = wrap ? '0 : inc[LineW-1:0];
	assign tick_frame = frame_q ^ wrap;
	assign cleared    = flags_q & ~(item.data[FlagW-1:0] & ClearMask);
	assign row_full   = raster_d - FirstDraw;

	always_comb begin
		raster_d   = raster_q;
		frame_d    = frame_q;
		flags_d    = flags_q;
		en_d       = en_q;
		req_d      = req_q;
		cmp_d      = cmp_q;
		raise      = 1'b0;
		raise_mask = '0;
		result     = '0;
		unique case (item.func)
			FN_TICK: begin
				raster_d = tick_line;
				frame_d  = tick_frame;
				if (cmp_q == tick_line) begin
					raise      = 1'b1;
					raise_mask = RasterSrc;
				end
			end
			FN_EVENT: begin
				raise      = 1'b1;
				raise_mask = item.event_bits;
			end
			FN_WR_FLAGS: begin
				if (cleared == '0) begin
					flags_d = '0;
					req_d   = 1'b0;
				end else begin
					flags_d = cleared | AnyFlagBit;
				end
			end
			FN_WR_EN:    en_d = item.data[EnW-1:0];
			FN_RD_FLAGS: result.read_data = flags_q;
			FN_RD_EN:    result.read_data = {{(8-EnW){1'b0}}, en_q};
			FN_WR_CMP:   cmp_d = item.data;
			default: ;
		endcase
		if (raise) begin
			flags_d = flags_q | {{(FlagW-EnW){1'b0}}, raise_mask} | AnyFlagBit;
			if ((en_q & raise_mask) != '0)
				req_d = !item.cpu_accepts;
		end
		result.irq_line    = req_d;
		result.raster_line = raster_d;
		// visible rows only on ticks of a drawn frame
		if (item.func == FN_TICK && frame_d && raster_d >= FirstDraw && raster_d <= LastDraw) begin
			result.draw_valid = 1'b1;
			result.draw_row   = row_full[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raster_q <= '0;
			frame_q  <= 1'b1;
			flags_q  <= '0;
			en_q     <= '0;
			req_q    <= 1'b0;
			cmp_q    <= '0;
		end else if (step) begin
			raster_q <= raster_d;
			frame_q  <= frame_d;
			flags_q  <= flags_d;
			en_q     <= en_d;
			req_q    <= req_d;
			cmp_q    <= cmp_d;
		end
	end

	a_req_has_flag: assert property (@(posedge clk) disable iff (!arst_n)
		req_q |-> flags_q[FlagW-1])
		else $error("request line high with summary flag clear");

	a_flags_summary: assert property (@(posedge clk) disable iff (!arst_n)
		(flags_q != '0) |-> flags_q[FlagW-1])
		else $error("pending flag without summary bit");

	a_en_write: assert property (@(posedge clk) disable iff (!arst_n)
		(step && item.func == FN_WR_EN) |=> (en_q == $past(item.data[EnW-1:0])))
		else $error("enable write not loaded");

endmodule

### test/raster_interrupt_controller_tb.sv
// self-checking stream testbench of the raster interrupt controller
`timescale 1ns / 1ps

module raster_interrupt_controller_tb;
	import ric_pkg::*;

	// func code that the block does not decode
	localparam logic [2:0] FnSpare = 3'd7;
	localparam int unsigned GapPct = 26;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // data[8:0], event_bits[12:9], cpu_accepts[13], zero pad
	logic [2:0]  s_tuser = '0;   // func[2:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // read_data[7:0], irq_line[8], raster_line[17:9],
	                             // draw_valid[18], draw_row[26:19], zero pad
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [LineW-1:0] cfg_data = '0;

	// controller state as predicted
	logic [LineW-1:0] line_limit = LastLineRst;
	logic [LineW-1:0] raster_now = '0;
	logic             frame_draw = 1'b1;
	logic [FlagW-1:0] flag_reg = '0;
	logic [EnW-1:0]   enable_reg = '0;
	logic             irq_req = 1'b0;
	logic [LineW-1:0] compare_at = '0;

	item_t       queued_commands[$];
	result_t     predicted_status[$];
	item_t       offered;
	int unsigned accepted_commands = 0;
	int unsigned mismatch_count = 0;
	bit          no_gaps = 1'b0;
	bit          rx_hold = 1'b0;

	raster_interrupt_controller DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

	function automatic void raise_sources(logic [EnW-1:0] src, logic accepts);
		flag_reg = flag_reg | {4'h0, src} | AnyFlagBit;
		if ((enable_reg & src) != '0) begin
			irq_req = !accepts;
		end
	endfunction

	function automatic result_t advance_controller(item_t cmd);
		result_t r;
		logic [LineW:0] nxt;
		r = '0;
		case (cmd.func)
			FN_TICK: begin
				nxt = {1'b0, raster_now} + 1'b1;
				if (nxt > {1'b0, line_limit} || nxt[LineW]) begin
					frame_draw = !frame_draw;
					nxt = '0;
				end
				raster_now = nxt[LineW-1:0];
				if (compare_at == raster_now)
					raise_sources(RasterSrc, cmd.cpu_accepts);
				if (frame_draw && raster_now >= FirstDraw && raster_now <= LastDraw) begin
					r.draw_valid = 1'b1;
					r.draw_row = 8'(raster_now - FirstDraw);
				end
			end
			FN_EVENT: raise_sources(cmd.event_bits, cmd.cpu_accepts);
			FN_WR_FLAGS: begin
				flag_reg = flag_reg & ~(cmd.data[7:0] & ClearMask);
				if (flag_reg == '0)
					irq_req = 1'b0;
				else
					flag_reg = flag_reg | AnyFlagBit;
			end
			FN_WR_EN: enable_reg = cmd.data[EnW-1:0];
			FN_RD_FLAGS: r.read_data = flag_reg;
			FN_RD_EN: r.read_data = {4'h0, enable_reg};
			FN_WR_CMP: compare_at = cmd.data;
			default: ;
		endcase
		r.irq_line = irq_req;
		r.raster_line = raster_now;
		return r;
	endfunction

	function automatic item_t make_cmd(logic [2:0] f, logic [8:0] d, logic [3:0] e, logic a);
		item_t c;
		c.func = f;
		c.data = d;
		c.event_bits = e;
		c.cpu_accepts = a;
		return c;
	endfunction

	function automatic item_t random_command(int unsigned tick_pct);
		item_t c;
		c.data = LineW'($urandom_range(0, 511));
		c.event_bits = EnW'($urandom_range(0, 15));
		c.cpu_accepts = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 99) < tick_pct)
			c.func = FN_TICK;
		else
			c.func = 3'($urandom_range(FN_EVENT, FnSpare));
		// keep compare lines reachable under the current wrap point
		if (c.func == FN_WR_CMP && $urandom_range(0, 1) == 1)
			c.data = LineW'($urandom_range(0, line_limit));
		return c;
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		$display("%0t: error on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic check_status(logic [31:0] word);
		result_t want;
		if (predicted_status.size() == 0) begin
			report_mismatch("unexpected word", word, 0);
		end else begin
			want = predicted_status.pop_front();
			if (word[7:0] !== want.read_data)
				report_mismatch("read_data", word[7:0], want.read_data);
			if (word[8] !== want.irq_line)
				report_mismatch("irq_line", word[8], want.irq_line);
			if (word[17:9] !== want.raster_line)
				report_mismatch("raster_line", word[17:9], want.raster_line);
			if (word[18] !== want.draw_valid)
				report_mismatch("draw_valid", word[18], want.draw_valid);
			if (word[26:19] !== want.draw_row)
				report_mismatch("draw_row", word[26:19], want.draw_row);
		end
	endtask

	// driver: offers queued words, predicts each one as it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				predicted_status.push_back(advance_controller(offered));
				accepted_commands++;
			end
			if (!s_tvalid || s_tready) begin
				if (queued_commands.size() != 0 && (no_gaps || $urandom_range(0, 99) >= GapPct)) begin
					offered = queued_commands.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {2'b00, offered.cpu_accepts, offered.event_bits, offered.data};
					s_tuser <= offered.func;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks result words and throttles the master side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				check_status(m_tdata);
			m_tready <= !rx_hold && (no_gaps || $urandom_range(0, 99) >= GapPct);
		end
	end

	// long back-pressure while the sender keeps offering
	initial begin
		wait (accepted_commands >= 150);
		@(posedge clk);
		rx_hold = 1'b1;
		repeat (200) @(posedge clk);
		rx_hold = 1'b0;
	end

	task automatic wait_drained();
		while (queued_commands.size() != 0 || s_tvalid || predicted_status.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_last_line(logic [LineW-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		line_limit = v;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic queue_random(int unsigned n, int unsigned tick_pct);
		repeat (n) queued_commands.push_back(random_command(tick_pct));
	endtask

	initial begin
		@(posedge arst_n);
		@(posedge clk);
		// directed: reset values, spare code, flag and request corner cases
		queued_commands.push_back(make_cmd(FN_RD_FLAGS, 9'h000, 4'h0, 1'b0));
		queued_commands.push_back(make_cmd(FN_RD_EN, 9'h000, 4'h0, 1'b0));
		queued_commands.push_back(make_cmd(FnSpare, 9'h1ff, 4'hf, 1'b1));
		queued_commands.push_back(make_cmd(FN_WR_EN, 9'h1f1, 4'h0, 1'b0));
		queued_commands.push_back(make_cmd(FN_RD_EN, 9'h000, 4'h0, 1'b0));
		queued_commands.push_back(make_cmd(FN_WR_CMP, 9'd2, 4'h0, 1'b0));
		queued_commands.push_back(make_cmd(FN_TICK, 9'h000, 4'h0, 1'b1));
		queued_commands.push_back(make_cmd(FN_TICK, 9'h000, 4'h0, 1'b0));
		queued_commands.push_back(make_cmd(FN_RD_FLAGS, 9'h000, 4'h0, 1'b0));
		queued_commands.push_back(make_cmd(FN_EVENT, 9'h000, 4'h0, 1'b1));
		queued_commands.push_back(make_cmd(FN_WR_FLAGS, 9'h100, 4'h0, 1'b0));
		queued_commands.push_back(make_cmd(FN_WR_FLAGS, 9'h001, 4'h0, 1'b0));
		queued_commands.push_back(make_cmd(FN_WR_FLAGS, 9'h080, 4'h0, 1'b0));
		queued_commands.push_back(make_cmd(FN_WR_EN, 9'h00f, 4'h0, 1'b0));
		queued_commands.push_back(make_cmd(FN_EVENT, 9'h000, 4'hf, 1'b1));
		queued_commands.push_back(make_cmd(FN_RD_FLAGS, 9'h000, 4'h0, 1'b0));
		queued_commands.push_back(make_cmd(FN_WR_FLAGS, 9'h0ff, 4'h0, 1'b0));
		queued_commands.push_back(make_cmd(FN_EVENT, 9'h1ff, 4'ha, 1'b0));
		queued_commands.push_back(make_cmd(FN_WR_FLAGS, 9'h08a, 4'h0, 1'b0));
		queued_commands.push_back(make_cmd(FN_WR_CMP, 9'h1ff, 4'h0, 1'b0));
		queued_commands.push_back(make_cmd(FN_TICK, 9'h000, 4'h0, 1'b0));
		queued_commands.push_back(make_cmd(FN_EVENT, 9'h000, 4'h5, 1'b0));
		queued_commands.push_back(make_cmd(FN_WR_EN, 9'h000, 4'h0, 1'b0));
		queued_commands.push_back(make_cmd(FN_RD_EN, 9'h000, 4'h0, 1'b0));
		wait_drained();

		write_last_line(LastLineRst);
		queue_random(350, 50);
		// sender pauses here until every result is back
		wait_drained();
		queue_random(350, 50);
		wait_drained();

		// tick-heavy run up to the top line, no gaps on either side
		write_last_line(9'd511);
		no_gaps = 1'b1;
		queue_random(650, 90);
		wait_drained();
		no_gaps = 1'b0;

		// raster likely sits past the new last line here
		write_last_line(9'd1);
		queue_random(200, 40);
		wait_drained();

		write_last_line(LineW'($urandom_range(40, 400)));
		queue_random(350, 60);
		wait_drained();

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
